### sv/msu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msu_pkg
// Shared types and constants of the multichannel soft UART.
// ----------------------------------------------------------------------------
package msu_pkg;

   localparam int DEF_CHANNELS   = 2;
   localparam int DEF_FIFO_DEPTH = 16;

   localparam int BYTE_W = 8;   // data word
   localparam int CH_W   = 2;   // channel select field
   localparam int LVL_W  = 2;   // per-channel bitmaps on the ports
   localparam int CNT_W  = 4;   // bit counter

   localparam logic [CNT_W-1:0] CNT_FIRST = 4'd1;
   localparam logic [CNT_W-1:0] CNT_LAST  = 4'd8;   // last data bit
   localparam logic [CNT_W-1:0] CNT_STOP  = 4'd9;   // stop bit

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_EDGE = 2'd1,
      OP_PUT  = 2'd2,
      OP_GET  = 2'd3
   } msu_op_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_TX       = 2'd1,
      MODE_RX_START = 2'd2,
      MODE_RX_DATA  = 2'd3
   } msu_mode_type;

   // command to one channel for one accepted word
   typedef struct packed {
      logic              tick;
      logic              rx_edge;
      logic              put;
      logic              get;
      logic [BYTE_W-1:0] data;
      logic              level;
   } msu_cmd_type;

   // what one channel reports back for that word
   typedef struct packed {
      logic tx_line;      // line level after the word
      logic put_ok;
      logic rephase;
      logic read_valid;
      logic dropped;
   } msu_stat_type;

   typedef struct packed {
      logic [LVL_W-1:0]  tx_levels;
      logic [BYTE_W-1:0] read_data;
      logic              read_valid;
      logic              put_accepted;
      logic              rephase_tick;
      logic [LVL_W-1:0]  rx_dropped;
   } msu_rsp_type;

endpackage

### sv/msu_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msu_req_if
// Request channel: opcode, channel, data byte and sampled RX levels.
// ----------------------------------------------------------------------------
interface msu_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [msu_pkg::CH_W-1:0]    channel;
   logic [msu_pkg::BYTE_W-1:0]  data_byte;
   logic [msu_pkg::LVL_W-1:0]   rx_levels;

   modport source (output valid, opcode, channel, data_byte, rx_levels, input ready);
   modport sink   (input valid, opcode, channel, data_byte, rx_levels, output ready);
endinterface

### sv/msu_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msu_rsp_if
// Response channel: TX levels and the per-word status flags.
// ----------------------------------------------------------------------------
interface msu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [msu_pkg::LVL_W-1:0]   tx_levels;
   logic [msu_pkg::BYTE_W-1:0]  read_data;
   logic                        read_valid;
   logic                        put_accepted;
   logic                        rephase_tick;
   logic [msu_pkg::LVL_W-1:0]   rx_dropped;

   modport source (output valid, tx_levels, read_data, read_valid, put_accepted,
                   rephase_tick, rx_dropped, input ready);
   modport sink   (input valid, tx_levels, read_data, read_valid, put_accepted,
                   rephase_tick, rx_dropped, output ready);
endinterface

### sv/msu_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msu_chan
// One UART channel: shared TX/RX bit engine plus TX and RX FIFO memories.
// ----------------------------------------------------------------------------
module msu_chan #(
   parameter int FIFO_DEPTH = msu_pkg::DEF_FIFO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  msu_pkg::msu_cmd_type       cmd,
   output msu_pkg::msu_stat_type      stat,
   output logic [msu_pkg::BYTE_W-1:0] rd_data
);

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FIFO_DEPTH);

   logic [msu_pkg::BYTE_W-1:0] tx_mem [FIFO_DEPTH];
   logic [msu_pkg::BYTE_W-1:0] rx_mem [FIFO_DEPTH];
   logic [msu_pkg::BYTE_W-1:0] tx_q_ff, rx_q_ff;

   msu_pkg::msu_mode_type        mode_ff, mode_in;
   logic [msu_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [msu_pkg::BYTE_W-1:0]   shift_ff, shift_in;
   logic                         line_ff, line_in;
   logic                         load_ff, load_in;
   logic [PTR_W-1:0]             tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic [PTR_W-1:0]             rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [FILL_W-1:0]            tx_fill_ff, tx_fill_in, rx_fill_ff, rx_fill_in;

   logic [msu_pkg::BYTE_W-1:0]   shift_cur;
   logic [msu_pkg::CNT_W-1:0]    cnt_inc;
   logic [2:0]                   bit_idx;
   logic                         pop, push, put_ok, get_ok, dropped, rephase;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   // popped byte arrives from memory in the cycle after the pop
   assign shift_cur = load_ff ? tx_q_ff : shift_ff;
   assign cnt_inc   = cnt_ff + msu_pkg::CNT_FIRST;
   assign bit_idx   = 3'(cnt_inc - msu_pkg::CNT_FIRST);

   always_comb begin
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_cur;
      line_in  = line_ff;
      pop      = 1'b0;
      push     = 1'b0;
      dropped  = 1'b0;
      rephase  = 1'b0;
      put_ok   = cmd.put && (tx_fill_ff < FILL_MAX);
      get_ok   = cmd.get && (rx_fill_ff != '0);

      if (cmd.tick) begin
         case (mode_ff)
            msu_pkg::MODE_IDLE: begin
               if (tx_fill_ff != '0) begin
                  pop     = 1'b1;
                  cnt_in  = '0;
                  line_in = 1'b0;
                  mode_in = msu_pkg::MODE_TX;
               end
            end
            msu_pkg::MODE_TX: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= msu_pkg::CNT_FIRST && cnt_inc <= msu_pkg::CNT_LAST) begin
                  line_in = shift_cur[bit_idx];
               end else if (cnt_inc == msu_pkg::CNT_STOP) begin
                  line_in = 1'b1;
               end else begin
                  mode_in = msu_pkg::MODE_IDLE;
               end
            end
            msu_pkg::MODE_RX_START: begin
               cnt_in  = '0;
               mode_in = msu_pkg::MODE_RX_DATA;
            end
            default: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= msu_pkg::CNT_FIRST && cnt_inc <= msu_pkg::CNT_LAST) begin
                  shift_in[bit_idx] = shift_cur[bit_idx] | cmd.level;
               end else if (cnt_inc != msu_pkg::CNT_STOP) begin
                  if (rx_fill_ff < FILL_MAX) begin
                     push = 1'b1;
                  end else begin
                     dropped = 1'b1;
                  end
                  mode_in = msu_pkg::MODE_IDLE;
               end
            end
         endcase
      end else if (cmd.rx_edge && mode_ff == msu_pkg::MODE_IDLE) begin
         mode_in  = msu_pkg::MODE_RX_START;
         cnt_in   = '0;
         shift_in = '0;
         rephase  = 1'b1;
      end

      load_in    = pop;
      tx_wr_in   = put_ok ? ptr_next(tx_wr_ff) : tx_wr_ff;
      tx_rd_in   = pop    ? ptr_next(tx_rd_ff) : tx_rd_ff;
      rx_wr_in   = push   ? ptr_next(rx_wr_ff) : rx_wr_ff;
      rx_rd_in   = get_ok ? ptr_next(rx_rd_ff) : rx_rd_ff;
      // a word is one opcode, so at most one of put/pop and push/get
      tx_fill_in = tx_fill_ff + FILL_W'(put_ok) - FILL_W'(pop);
      rx_fill_in = rx_fill_ff + FILL_W'(push) - FILL_W'(get_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= msu_pkg::MODE_IDLE;
         cnt_ff     <= '0;
         shift_ff   <= '0;
         line_ff    <= 1'b1;
         load_ff    <= 1'b0;
         tx_wr_ff   <= '0;
         tx_rd_ff   <= '0;
         rx_wr_ff   <= '0;
         rx_rd_ff   <= '0;
         tx_fill_ff <= '0;
         rx_fill_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         cnt_ff     <= cnt_in;
         shift_ff   <= shift_in;
         line_ff    <= line_in;
         load_ff    <= load_in;
         tx_wr_ff   <= tx_wr_in;
         tx_rd_ff   <= tx_rd_in;
         rx_wr_ff   <= rx_wr_in;
         rx_rd_ff   <= rx_rd_in;
         tx_fill_ff <= tx_fill_in;
         rx_fill_ff <= rx_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put_ok) begin
         tx_mem[tx_wr_ff] <= cmd.data;
      end
      if (pop) begin
         tx_q_ff <= tx_mem[tx_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rx_mem[rx_wr_ff] <= shift_cur;
      end
      if (get_ok) begin
         rx_q_ff <= rx_mem[rx_rd_ff];
      end
   end

   assign stat.tx_line    = line_in;
   assign stat.put_ok     = put_ok;
   assign stat.rephase    = rephase;
   assign stat.read_valid = get_ok;
   assign stat.dropped    = dropped;
   assign rd_data         = rx_q_ff;

   a_tx_fill_bound: assert property (@(posedge clock) disable iff (reset)
      tx_fill_ff <= FILL_MAX)
      else $error("tx fill count above depth");

   a_rx_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rx_fill_ff <= FILL_MAX)
      else $error("rx fill count above depth");

   a_load_in_tx: assert property (@(posedge clock) disable iff (reset)
      load_ff |-> (mode_ff == msu_pkg::MODE_TX && cnt_ff == '0))
      else $error("pending TX load outside start of transmit");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> tx_fill_ff != '0)
      else $error("pop from empty TX FIFO");

endmodule

### sv/multichannel_soft_uart.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_soft_uart
// Multi-channel half-duplex 8N1 UART with per-channel TX and RX FIFOs.
// ----------------------------------------------------------------------------
// Takes one request word per clock and returns exactly one response word per
// request, in order. Each response is held in the stage-1 register while the
// FIFO memory is read, and then written into the output queue; a
// two-entry output queue absorbs back-pressure, so the request side keeps
// taking a word every cycle as long as the response side drains. Each channel
// keeps its TX and RX bytes in two single-port-per-direction memories of
// FIFO_DEPTH entries; no clearing pass is needed after reset. Edge, put and
// get words aimed at a channel at or above CHANNELS do nothing and report all
// flags low. RX levels and TX/drop bitmaps carry the first two channels only.
// ----------------------------------------------------------------------------
module multichannel_soft_uart #(
   parameter int CHANNELS   = msu_pkg::DEF_CHANNELS,
   parameter int FIFO_DEPTH = msu_pkg::DEF_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   msu_req_if.sink     req_if,
   msu_rsp_if.source   rsp_if
);

   localparam int LVL_W  = msu_pkg::LVL_W;
   localparam int BYTE_W = msu_pkg::BYTE_W;

   msu_pkg::msu_cmd_type       cmd  [CHANNELS];
   msu_pkg::msu_stat_type      stat [CHANNELS];
   logic [BYTE_W-1:0]          rdq  [CHANNELS];

   logic                       req_fire, rsp_fire;
   logic [2:0]                 room_sum;

   // stage 1: flags from the channels, waiting on memory read data
   logic                       p1_valid_ff, p1_valid_in;
   msu_pkg::msu_rsp_type       p1_ff, p1_in;
   logic [msu_pkg::CH_W-1:0]   p1_ch_ff;
   msu_pkg::msu_rsp_type       p1_word;
   logic [BYTE_W-1:0]          p1_rd;

   // output queue
   msu_pkg::msu_rsp_type       oq_ff [2];
   logic                       oq_head_ff, oq_head_in;
   logic [1:0]                 oq_cnt_ff, oq_cnt_in;
   logic                       oq_wr_idx;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   // room counts the queue, the word in stage 1 and a word leaving now
   assign room_sum     = {1'b0, oq_cnt_ff} + {2'b0, p1_valid_ff} - {2'b0, rsp_fire};
   assign req_if.ready = room_sum < 3'd2;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic addr_hit;
      logic lvl_bit;
      assign addr_hit = (32'(req_if.channel) == c);

      if (c < LVL_W) begin : g_lvl
         assign lvl_bit = req_if.rx_levels[c];
      end else begin : g_nolvl
         assign lvl_bit = 1'b0;
      end

      always_comb begin
         cmd[c].tick    = req_fire && (req_if.opcode == msu_pkg::OP_TICK);
         cmd[c].rx_edge = req_fire && (req_if.opcode == msu_pkg::OP_EDGE) && addr_hit;
         cmd[c].put     = req_fire && (req_if.opcode == msu_pkg::OP_PUT) && addr_hit;
         cmd[c].get     = req_fire && (req_if.opcode == msu_pkg::OP_GET) && addr_hit;
         cmd[c].data    = req_if.data_byte;
         cmd[c].level   = lvl_bit;
      end

      msu_chan #(
         .FIFO_DEPTH (FIFO_DEPTH)
      ) u_chan (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd[c]),
         .stat    (stat[c]),
         .rd_data (rdq[c])
      );
   end

   always_comb begin
      p1_in              = '0;
      p1_in.tx_levels    = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (c < LVL_W) begin
            p1_in.tx_levels[c]  = stat[c].tx_line;
            p1_in.rx_dropped[c] = stat[c].dropped;
         end
         p1_in.read_valid   = p1_in.read_valid   | stat[c].read_valid;
         p1_in.put_accepted = p1_in.put_accepted | stat[c].put_ok;
         p1_in.rephase_tick = p1_in.rephase_tick | stat[c].rephase;
      end
      p1_valid_in = req_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_ff    <= p1_in;
         p1_ch_ff <= req_if.channel;
      end
   end

   // pick the addressed channel's read data
   always_comb begin
      p1_rd = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (32'(p1_ch_ff) == c) begin
            p1_rd = rdq[c];
         end
      end
      p1_word           = p1_ff;
      p1_word.read_data = p1_ff.read_valid ? p1_rd : '0;
   end

   assign oq_wr_idx  = oq_head_ff ^ oq_cnt_ff[0];
   assign oq_head_in = oq_head_ff ^ rsp_fire;
   assign oq_cnt_in  = oq_cnt_ff + {1'b0, p1_valid_ff} - {1'b0, rsp_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_head_ff <= 1'b0;
         oq_cnt_ff  <= '0;
      end else begin
         oq_head_ff <= oq_head_in;
         oq_cnt_ff  <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         oq_ff[oq_wr_idx] <= p1_word;
      end
   end

   assign rsp_if.valid        = oq_cnt_ff != '0;
   assign rsp_if.tx_levels    = oq_ff[oq_head_ff].tx_levels;
   assign rsp_if.read_data    = oq_ff[oq_head_ff].read_data;
   assign rsp_if.read_valid   = oq_ff[oq_head_ff].read_valid;
   assign rsp_if.put_accepted = oq_ff[oq_head_ff].put_accepted;
   assign rsp_if.rephase_tick = oq_ff[oq_head_ff].rephase_tick;
   assign rsp_if.rx_dropped   = oq_ff[oq_head_ff].rx_dropped;

   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= 2'd2)
      else $error("output queue overfilled");

   a_p1_has_room: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (oq_cnt_ff != 2'd2 || rsp_fire))
      else $error("stage 1 word with no queue slot");

   a_accept_to_p1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> p1_valid_ff)
      else $error("accepted word lost before stage 1");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |->
         $countones({p1_ff.read_valid, p1_ff.put_accepted, p1_ff.rephase_tick}) <= 1)
      else $error("more than one operation flag in one response");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel soft UART.
// ----------------------------------------------------------------------------
// Every word the block takes is also run through a behavioral copy of the
// channel state machines and FIFOs kept here; the status due for it is queued
// and compared field by field with each response word, in order. A short
// directed table opens the run. Random frames follow: they are edge-then-tick
// sequences with puts, gets and stray words mixed in. The phases push the TX
// FIFOs full, drain them, flood the RX FIFOs until bytes drop, then read back.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CHANNELS    = msu_pkg::DEF_CHANNELS;
   localparam int DEPTH       = msu_pkg::DEF_FIFO_DEPTH;
   localparam int HOLD_CYCLES = 60;     // long response-side hold-off
   localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
   localparam int NUM_ROWS    = 25;

   typedef struct {
      msu_pkg::msu_op_type  op;
      logic [1:0]           ch;
      logic [7:0]           data;
      logic [1:0]           lvl;
      bit                   typed;
      msu_pkg::msu_rsp_type want;
   } uart_word_type;

   // directed row: stimulus plus the status typed in where it is obvious
   typedef struct {
      msu_pkg::msu_op_type op;
      logic [1:0] ch;
      logic [7:0] data;
      logic [1:0] lvl;
      bit         typed;
      logic [1:0] tx;
      logic [7:0] rdata;
      logic       rvalid;
      logic       put_ok;
      logic       rephase;
      logic [1:0] dropped;
   } dir_row_type;

   logic clock;
   logic reset;

   msu_req_if req_bus ();
   msu_rsp_if rsp_bus ();

   multichannel_soft_uart uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // channel state mirrored here
   msu_pkg::msu_mode_type chan_mode [CHANNELS];
   logic [3:0]   bit_cnt   [CHANNELS];
   logic [7:0]   shreg     [CHANNELS];
   logic         line_lvl  [CHANNELS];
   logic [7:0]   tx_mem    [CHANNELS][DEPTH];
   int           tx_rd     [CHANNELS];
   int           tx_cnt    [CHANNELS];
   logic [7:0]   rx_mem    [CHANNELS][DEPTH];
   int           rx_rd     [CHANNELS];
   int           rx_cnt    [CHANNELS];

   msu_pkg::msu_rsp_type status_due [$];
   uart_word_type on_bus;
   int          words_sent;
   int          statuses_seen;
   int          mismatches;
   int          quiet_cycles;
   bit          bursts_on;
   bit          rsp_hold_request;

   dir_row_type directed_rows [NUM_ROWS] = '{
      '{msu_pkg::OP_GET,  2'd0, 8'h00, 2'b00, 1'b1, 2'b11, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_GET,  2'd1, 8'hFF, 2'b11, 1'b1, 2'b11, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_EDGE, 2'd2, 8'h00, 2'b00, 1'b1, 2'b11, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_EDGE, 2'd3, 8'hFF, 2'b11, 1'b1, 2'b11, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_PUT,  2'd3, 8'hFF, 2'b00, 1'b1, 2'b11, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_GET,  2'd2, 8'h00, 2'b11, 1'b1, 2'b11, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_PUT,  2'd0, 8'h00, 2'b00, 1'b1, 2'b11, 8'h00, 1'b0, 1'b1, 1'b0, 2'b00},
      '{msu_pkg::OP_PUT,  2'd1, 8'hFF, 2'b00, 1'b1, 2'b11, 8'h00, 1'b0, 1'b1, 1'b0, 2'b00},
      '{msu_pkg::OP_PUT,  2'd0, 8'hA5, 2'b00, 1'b1, 2'b11, 8'h00, 1'b0, 1'b1, 1'b0, 2'b00},
      // both channels leave idle with a start bit
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b11, 1'b1, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      // edge while transmitting is ignored
      '{msu_pkg::OP_EDGE, 2'd0, 8'h00, 2'b00, 1'b1, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b00, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd1, 8'h00, 2'b01, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd2, 8'h00, 2'b10, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd3, 8'h00, 2'b11, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b00, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b11, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b01, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b10, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b00, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b11, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      // both idle again; ch0 still holds a byte but an edge wins first
      '{msu_pkg::OP_EDGE, 2'd1, 8'h00, 2'b00, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_EDGE, 2'd1, 8'h00, 2'b00, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_EDGE, 2'd0, 8'h00, 2'b00, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00},
      '{msu_pkg::OP_TICK, 2'd0, 8'h00, 2'b01, 1'b0, 2'b00, 8'h00, 1'b0, 1'b0, 1'b0, 2'b00}
   };

   // advance the mirrored channels by one word and return its status
   function automatic msu_pkg::msu_rsp_type step_channels(input uart_word_type w);
      msu_pkg::msu_rsp_type st;
      int          c;
      st = '0;
      case (w.op)
         msu_pkg::OP_TICK: begin
            for (c = 0; c < CHANNELS; c++) begin
               case (chan_mode[c])
                  msu_pkg::MODE_IDLE: begin
                     if (tx_cnt[c] != 0) begin
                        shreg[c]     = tx_mem[c][tx_rd[c]];
                        tx_rd[c]     = (tx_rd[c] + 1) % DEPTH;
                        tx_cnt[c]    = tx_cnt[c] - 1;
                        bit_cnt[c]   = '0;
                        line_lvl[c]  = 1'b0;
                        chan_mode[c] = msu_pkg::MODE_TX;
                     end
                  end
                  msu_pkg::MODE_TX: begin
                     bit_cnt[c] = bit_cnt[c] + 4'd1;
                     if (bit_cnt[c] >= msu_pkg::CNT_FIRST && bit_cnt[c] <= msu_pkg::CNT_LAST)
                        line_lvl[c] = shreg[c][bit_cnt[c] - 4'd1];
                     else if (bit_cnt[c] == msu_pkg::CNT_STOP)
                        line_lvl[c] = 1'b1;
                     else
                        chan_mode[c] = msu_pkg::MODE_IDLE;
                  end
                  msu_pkg::MODE_RX_START: begin
                     bit_cnt[c]   = '0;
                     chan_mode[c] = msu_pkg::MODE_RX_DATA;
                  end
                  default: begin
                     bit_cnt[c] = bit_cnt[c] + 4'd1;
                     if (bit_cnt[c] >= msu_pkg::CNT_FIRST && bit_cnt[c] <= msu_pkg::CNT_LAST) begin
                        if (w.lvl[c])
                           shreg[c][bit_cnt[c] - 4'd1] = 1'b1;
                     end else if (bit_cnt[c] != msu_pkg::CNT_STOP) begin
                        // stop bit is never checked; the byte lands or drops here
                        if (rx_cnt[c] < DEPTH) begin
                           rx_mem[c][(rx_rd[c] + rx_cnt[c]) % DEPTH] = shreg[c];
                           rx_cnt[c] = rx_cnt[c] + 1;
                        end else begin
                           st.rx_dropped[c] = 1'b1;
                        end
                        chan_mode[c] = msu_pkg::MODE_IDLE;
                     end
                  end
               endcase
            end
         end
         msu_pkg::OP_EDGE: begin
            if (w.ch < CHANNELS && chan_mode[w.ch] == msu_pkg::MODE_IDLE) begin
               chan_mode[w.ch] = msu_pkg::MODE_RX_START;
               bit_cnt[w.ch]   = '0;
               shreg[w.ch]     = '0;
               st.rephase_tick = 1'b1;
            end
         end
         msu_pkg::OP_PUT: begin
            if (w.ch < CHANNELS && tx_cnt[w.ch] < DEPTH) begin
               tx_mem[w.ch][(tx_rd[w.ch] + tx_cnt[w.ch]) % DEPTH] = w.data;
               tx_cnt[w.ch]    = tx_cnt[w.ch] + 1;
               st.put_accepted = 1'b1;
            end
         end
         default: begin
            if (w.ch < CHANNELS && rx_cnt[w.ch] != 0) begin
               st.read_data  = rx_mem[w.ch][rx_rd[w.ch]];
               rx_rd[w.ch]   = (rx_rd[w.ch] + 1) % DEPTH;
               rx_cnt[w.ch]  = rx_cnt[w.ch] - 1;
               st.read_valid = 1'b1;
            end
         end
      endcase
      for (c = 0; c < CHANNELS; c++)
         st.tx_levels[c] = line_lvl[c];
      return st;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic send_word(input msu_pkg::msu_op_type op, input logic [1:0] ch,
                            input logic [7:0] data, input logic [1:0] lvl,
                            input bit typed = 1'b0,
                            input msu_pkg::msu_rsp_type want = '0);
      int gap;
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      on_bus.op    = op;
      on_bus.ch    = ch;
      on_bus.data  = data;
      on_bus.lvl   = lvl;
      on_bus.typed = typed;
      on_bus.want  = want;
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.channel   <= ch;
      req_bus.data_byte <= data;
      req_bus.rx_levels <= lvl;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      words_sent++;
   endtask

   // stop offering and wait until every outstanding status has come back
   task automatic drain_pause();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (statuses_seen == words_sent);
   endtask

   // optional edges, then a run of ticks with puts, gets and stray words mixed in
   task automatic line_frame(input int ticks, input int put_pct, input int get_pct,
                             input int edge_pct, input int noise_pct);
      int c;
      for (c = 0; c < CHANNELS; c++)
         if ($urandom_range(0, 99) < edge_pct)
            send_word(msu_pkg::OP_EDGE, 2'(c), 8'($urandom), 2'($urandom));
      repeat (ticks) begin
         if ($urandom_range(0, 99) < put_pct)
            send_word(msu_pkg::OP_PUT, 2'($urandom_range(0, CHANNELS - 1)), 8'($urandom),
                      2'($urandom));
         if ($urandom_range(0, 99) < get_pct)
            send_word(msu_pkg::OP_GET, 2'($urandom_range(0, CHANNELS - 1)), 8'($urandom),
                      2'($urandom));
         if ($urandom_range(0, 99) < noise_pct)
            send_word(msu_pkg::msu_op_type'($urandom_range(0, 3)), 2'($urandom), 8'($urandom),
                      2'($urandom));
         send_word(msu_pkg::OP_TICK, 2'($urandom), 8'($urandom), 2'($urandom));
      end
   endtask

   initial clock = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // word taken: run it through the mirrored channels
   always @(posedge clock) begin
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
         status_due.push_back(on_bus.typed ? on_bus.want : step_channels(on_bus));
   end

   // typed rows must still advance the mirrored state
   always @(posedge clock) begin
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1 && on_bus.typed)
         void'(step_channels(on_bus));
   end

   always @(posedge clock) begin
      msu_pkg::msu_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (status_due.size() == 0) begin
            $display("%0t: response word with nothing outstanding", $time);
            mismatches++;
         end else begin
            want = status_due.pop_front();
            check_field("tx_levels", 8'(want.tx_levels), 8'(rsp_bus.tx_levels));
            check_field("read_data", want.read_data, rsp_bus.read_data);
            check_field("read_valid", 8'(want.read_valid), 8'(rsp_bus.read_valid));
            check_field("put_accepted", 8'(want.put_accepted), 8'(rsp_bus.put_accepted));
            check_field("rephase_tick", 8'(want.rephase_tick), 8'(rsp_bus.rephase_tick));
            check_field("rx_dropped", 8'(want.rx_dropped), 8'(rsp_bus.rx_dropped));
            statuses_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** multichannel_soft_uart: FAILED **");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            rsp_hold_request = 1'b0;
         end else if (bursts_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int          i;
      msu_pkg::msu_rsp_type want_w;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = msu_pkg::OP_TICK;
      req_bus.channel   = '0;
      req_bus.data_byte = '0;
      req_bus.rx_levels = '0;
      words_sent        = 0;
      statuses_seen     = 0;
      mismatches        = 0;
      bursts_on         = 1'b1;
      rsp_hold_request  = 1'b0;
      for (i = 0; i < CHANNELS; i++) begin
         chan_mode[i] = msu_pkg::MODE_IDLE;
         bit_cnt[i]   = '0;
         shreg[i]     = '0;
         line_lvl[i]  = 1'b1;
         tx_rd[i]     = 0;
         tx_cnt[i]    = 0;
         rx_rd[i]     = 0;
         rx_cnt[i]    = 0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_ROWS; i++) begin
         want_w = {directed_rows[i].tx, directed_rows[i].rdata, directed_rows[i].rvalid,
                   directed_rows[i].put_ok, directed_rows[i].rephase,
                   directed_rows[i].dropped};
         send_word(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].data,
                   directed_rows[i].lvl, directed_rows[i].typed, want_w);
      end
      drain_pause();

      // mixed traffic, some frames cut short or overlong
      repeat (6) line_frame($urandom_range(10, 12), 15, 15, 80, 5);

      // fill both TX FIFOs past full while the response side is held off
      rsp_hold_request = 1'b1;
      for (i = 0; i < 40; i++)
         send_word(msu_pkg::OP_PUT, 2'(i % CHANNELS), 8'($urandom), 2'($urandom));

      // send them all out; edges mostly land on busy channels
      repeat (16) line_frame(11, 0, 10, 60, 3);
      drain_pause();

      // back-to-back receptions with no reads, until bytes drop
      repeat (20) line_frame(11, 0, 0, 100, 0);

      for (i = 0; i < 40; i++)
         send_word(msu_pkg::OP_GET, 2'(i % CHANNELS), 8'($urandom), 2'($urandom));

      bursts_on = 1'b0;
      repeat (4) line_frame(11, 20, 20, 80, 5);

      drain_pause();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && status_due.size() == 0)
         $display("** multichannel_soft_uart: PASSED **");
      else
         $display("** multichannel_soft_uart: FAILED **");
      $finish;
   end

endmodule

### multichannel_soft_uart.f
sv/msu_pkg.sv
sv/msu_req_if.sv
sv/msu_rsp_if.sv
sv/msu_chan.sv
sv/multichannel_soft_uart.sv
sim/testbench.sv
